>>> rtl/core/kpl_pkg.sv
// ----------------------------------------------------------------------------
// kpl_pkg: shared types and constants for the keypad code-entry lock
// Phase, command and echo codes, key characters and the stream layouts.
// ----------------------------------------------------------------------------
package kpl_pkg;

  // Entry phase, as shown on the result stream
  typedef enum logic [2:0] {
    PH_WELCOME = 3'd0,
    PH_ID      = 3'd1,
    PH_PASS    = 3'd2,
    PH_SUBMIT  = 3'd3,
    PH_LOCKED  = 3'd4
  } phase_e;

  // Request kind, carried in the input tuser
  localparam logic [1:0] CMD_KEY     = 2'd0;
  localparam logic [1:0] CMD_TIMEOUT = 2'd1;
  localparam logic [1:0] CMD_VERIFY  = 2'd2;

  // Display action, carried in the output tuser
  localparam logic [1:0] ECHO_NONE  = 2'd0;
  localparam logic [1:0] ECHO_DIGIT = 2'd1;
  localparam logic [1:0] ECHO_MASK  = 2'd2;
  localparam logic [1:0] ECHO_ERASE = 2'd3;

  // Key characters
  localparam logic [7:0] KEY_HASH  = 8'h23;
  localparam logic [7:0] KEY_CLEAR = 8'h43;
  localparam logic [7:0] KEY_ZERO  = 8'h30;
  localparam logic [7:0] KEY_NINE  = 8'h39;
  localparam logic [7:0] CHAR_MASK = 8'h2A;

  localparam logic [3:0] ATTEMPT_MAX   = 4'd15;
  localparam logic [3:0] ATTEMPT_RESET = 4'd3;

  // Stream widths
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 56;
  localparam int unsigned OUT_USER_W = 2;

  // Result word, first field in the highest bits of tdata
  typedef struct packed {
    logic       locked;
    logic       granted;
    logic [3:0] wrong_count;
    logic [2:0] pass_length;
    logic [15:0] pass_digits;
    logic [2:0] id_length;
    logic [15:0] id_digits;
    logic       submit;
    logic [7:0] echo_char;
    logic [2:0] phase;
  } result_t;

endpackage

>>> rtl/core/keypad_code_entry_lock.sv
// ----------------------------------------------------------------------------
// keypad_code_entry_lock: keypad ID/password entry with attempt lockout
// Results are registered; one request per cycle while the skid slot is empty.
// A two-deep output buffer keeps input ready while one result waits.
// Reset returns to welcome, clears both codes and counts, sets limit to 3.
// ----------------------------------------------------------------------------
module keypad_code_entry_lock #(
  parameter int unsigned CODE_DIGITS = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration: max_attempts
  input  logic                              cfg_we_i,
  input  logic [3:0]                        cfg_wdata_i,
  // request stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: key_code [7:0], match [8], zero fill [15:9]
  input  logic [kpl_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser: cmd [1:0]
  input  logic [kpl_pkg::IN_USER_W-1:0]     s_axis_tuser,
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: phase [2:0], echo_char [10:3], submit [11], id_digits [27:12],
  //        id_length [30:28], pass_digits [46:31], pass_length [49:47],
  //        wrong_count [53:50], granted [54], locked [55]
  output logic [kpl_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // tuser: echo_kind [1:0]
  output logic [kpl_pkg::OUT_USER_W-1:0]    m_axis_tuser
);

  localparam int unsigned CNT_W = $clog2(CODE_DIGITS + 1);
  localparam int unsigned IDX_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam int unsigned PACK_W = 4 * CODE_DIGITS;

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  kpl_pkg::phase_e   phase_q, phase_d;
  logic [3:0]        id_q [CODE_DIGITS];
  logic [3:0]        id_d [CODE_DIGITS];
  logic [3:0]        pass_q [CODE_DIGITS];
  logic [3:0]        pass_d [CODE_DIGITS];
  logic [CNT_W-1:0]  id_cnt_q, id_cnt_d;
  logic [CNT_W-1:0]  pass_cnt_q, pass_cnt_d;
  logic [3:0]        attempt_q, attempt_d;
  logic [3:0]        max_att_q;

  logic              push, pop;
  logic [1:0]        cmd;
  logic [7:0]        key;
  logic              match;

  // per-step echo and pulses
  logic [1:0]        echo_kind;
  logic [7:0]        echo_char;
  logic              submit, granted;

  // field editor working copies
  logic              fld_pass;
  logic [3:0]        fld_st [CODE_DIGITS];
  logic [CNT_W-1:0]  fld_cnt;
  logic [CNT_W-1:0]  fld_cnt_dec;
  logic              is_digit;

  logic [PACK_W-1:0]    id_pack, pass_pack;
  logic [PACK_W+15:0]   id_wide, pass_wide;
  kpl_pkg::result_t     res;

  assign cmd   = s_axis_tuser[1:0];
  assign key   = s_axis_tdata[7:0];
  assign match = s_axis_tdata[8];

  assign is_digit    = (key >= kpl_pkg::KEY_ZERO) && (key <= kpl_pkg::KEY_NINE);
  assign fld_pass    = (phase_q == kpl_pkg::PH_PASS);
  assign fld_cnt     = fld_pass ? pass_cnt_q : id_cnt_q;
  assign fld_cnt_dec = fld_cnt - CNT_W'(1);

  // --------------------------------------------------------------------------
  // Next state for one request
  // --------------------------------------------------------------------------
  always_comb begin
    phase_d    = phase_q;
    id_d       = id_q;
    pass_d     = pass_q;
    id_cnt_d   = id_cnt_q;
    pass_cnt_d = pass_cnt_q;
    attempt_d  = attempt_q;
    echo_kind  = kpl_pkg::ECHO_NONE;
    echo_char  = 8'd0;
    submit     = 1'b0;
    granted    = 1'b0;
    if (fld_pass) begin
      fld_st = pass_q;
    end else begin
      fld_st = id_q;
    end

    if (phase_q != kpl_pkg::PH_LOCKED) begin
      case (cmd)
        kpl_pkg::CMD_KEY: begin
          case (phase_q)
            kpl_pkg::PH_WELCOME: begin
              if (key == kpl_pkg::KEY_HASH) begin
                for (int i = 0; i < CODE_DIGITS; i++) begin
                  id_d[i]   = 4'd0;
                  pass_d[i] = 4'd0;
                end
                id_cnt_d   = '0;
                pass_cnt_d = '0;
                phase_d    = kpl_pkg::PH_ID;
              end
            end
            kpl_pkg::PH_ID, kpl_pkg::PH_PASS: begin
              if (key == kpl_pkg::KEY_HASH) begin
                if (fld_pass) begin
                  phase_d = kpl_pkg::PH_SUBMIT;
                  submit  = 1'b1;
                end else begin
                  phase_d = kpl_pkg::PH_PASS;
                end
              end else begin
                // edit the field of the current phase
                if (key == kpl_pkg::KEY_CLEAR) begin
                  if (fld_cnt != '0) begin
                    fld_st[fld_cnt_dec[IDX_W-1:0]] = 4'd0;
                    echo_kind = kpl_pkg::ECHO_ERASE;
                    if (fld_pass) begin
                      pass_d     = fld_st;
                      pass_cnt_d = fld_cnt_dec;
                    end else begin
                      id_d     = fld_st;
                      id_cnt_d = fld_cnt_dec;
                    end
                  end
                end else if (is_digit && (fld_cnt < CNT_W'(CODE_DIGITS))) begin
                  fld_st[fld_cnt[IDX_W-1:0]] = key[3:0];
                  if (fld_pass) begin
                    pass_d     = fld_st;
                    pass_cnt_d = fld_cnt + CNT_W'(1);
                    echo_kind  = kpl_pkg::ECHO_MASK;
                    echo_char  = kpl_pkg::CHAR_MASK;
                  end else begin
                    id_d      = fld_st;
                    id_cnt_d  = fld_cnt + CNT_W'(1);
                    echo_kind = kpl_pkg::ECHO_DIGIT;
                    echo_char = key;
                  end
                end
              end
            end
            default: begin
              // submitted: any key returns to welcome, codes kept
              phase_d = kpl_pkg::PH_WELCOME;
            end
          endcase
        end
        kpl_pkg::CMD_TIMEOUT: begin
          if (phase_q != kpl_pkg::PH_WELCOME) begin
            phase_d = kpl_pkg::PH_WELCOME;
            for (int i = 0; i < CODE_DIGITS; i++) begin
              id_d[i]   = 4'd0;
              pass_d[i] = 4'd0;
            end
            id_cnt_d   = '0;
            pass_cnt_d = '0;
          end
        end
        kpl_pkg::CMD_VERIFY: begin
          if (phase_q == kpl_pkg::PH_SUBMIT) begin
            if (match) begin
              attempt_d = 4'd0;
              granted   = 1'b1;
            end else begin
              if (attempt_q != kpl_pkg::ATTEMPT_MAX) begin
                attempt_d = attempt_q + 4'd1;
              end
              if (attempt_d >= max_att_q) begin
                phase_d = kpl_pkg::PH_LOCKED;
              end
            end
          end
        end
        default: begin
          // unused command: no change
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Result word: first digit in the high nibble, low 16 bits shown
  // --------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < CODE_DIGITS; i++) begin
      id_pack[4*(CODE_DIGITS-1-i) +: 4]   = id_d[i];
      pass_pack[4*(CODE_DIGITS-1-i) +: 4] = pass_d[i];
    end
  end

  assign id_wide   = {16'd0, id_pack};
  assign pass_wide = {16'd0, pass_pack};

  always_comb begin
    res.phase       = phase_d;
    res.echo_char   = echo_char;
    res.submit      = submit;
    res.id_digits   = id_wide[15:0];
    res.id_length   = 3'(id_cnt_d);
    res.pass_digits = pass_wide[15:0];
    res.pass_length = 3'(pass_cnt_d);
    res.wrong_count = attempt_d;
    res.granted     = granted;
    res.locked      = (phase_d == kpl_pkg::PH_LOCKED);
  end

  // --------------------------------------------------------------------------
  // State registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= kpl_pkg::PH_WELCOME;
      id_cnt_q   <= '0;
      pass_cnt_q <= '0;
      attempt_q  <= 4'd0;
      for (int i = 0; i < CODE_DIGITS; i++) begin
        id_q[i]   <= 4'd0;
        pass_q[i] <= 4'd0;
      end
    end else if (push) begin
      phase_q    <= phase_d;
      id_cnt_q   <= id_cnt_d;
      pass_cnt_q <= pass_cnt_d;
      attempt_q  <= attempt_d;
      id_q       <= id_d;
      pass_q     <= pass_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_att_q <= kpl_pkg::ATTEMPT_RESET;
    end else if (cfg_we_i) begin
      max_att_q <= cfg_wdata_i;
    end
  end

  // --------------------------------------------------------------------------
  // Output register with skid slot
  // --------------------------------------------------------------------------
  logic                              out_vld_q, skid_vld_q;
  logic [kpl_pkg::OUT_DATA_W-1:0]    out_data_q, skid_data_q;
  logic [kpl_pkg::OUT_USER_W-1:0]    out_user_q, skid_user_q;

  assign s_axis_tready = !skid_vld_q;
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = out_vld_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (pop) begin
        out_vld_q  <= skid_vld_q || push;
        skid_vld_q <= 1'b0;
      end else if (push) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= out_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && skid_vld_q) begin
      // advance the held result
      out_data_q <= skid_data_q;
      out_user_q <= skid_user_q;
    end else if (push && (pop || !out_vld_q)) begin
      out_data_q <= res;
      out_user_q <= echo_kind;
    end
    if (push && out_vld_q && !pop) begin
      skid_data_q <= res;
      skid_user_q <= echo_kind;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

>>> rtl/core/kpl_checker.sv
// ----------------------------------------------------------------------------
// kpl_checker: port-level checks for the keypad code-entry lock
// Result consistency and output stream rules, bound to the top level.
// ----------------------------------------------------------------------------
module kpl_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [kpl_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  logic [2:0] phase;
  logic       submit, granted, locked;
  logic [3:0] wrong_count;

  assign phase       = m_axis_tdata[2:0];
  assign submit      = m_axis_tdata[11];
  assign wrong_count = m_axis_tdata[53:50];
  assign granted     = m_axis_tdata[54];
  assign locked      = m_axis_tdata[55];

  // locked flag tracks the locked phase
  a_locked_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (locked == (phase == kpl_pkg::PH_LOCKED)))
    else $error("locked flag disagrees with phase");

  // submit only on entering the submitted phase
  a_submit_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && submit) |-> (phase == kpl_pkg::PH_SUBMIT))
    else $error("submit outside submitted phase");

  // a grant clears the attempt count
  a_grant_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && granted) |-> (wrong_count == 4'd0 && !submit))
    else $error("grant with nonzero wrong count");

  // input back-pressure only while a result is pending
  a_ready_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind keypad_code_entry_lock kpl_checker u_kpl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
